// ===== sv/ffse_pkg.sv =====
// Package for the frame buffer fill and scroll engine.
// Holds the command and result word types, opcodes and register indexes.
// No dependencies.
package ffse_pkg;

   localparam logic [2:0] OP_FILL      = 3'd0;
   localparam logic [2:0] OP_SCROLL    = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_PAL_WRITE = 3'd3;
   localparam logic [2:0] OP_POLL      = 3'd4;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [8:0] SCREEN_WIDTH_RESET  = 9'd160;
   localparam logic [8:0] SCREEN_HEIGHT_RESET = 9'd128;

   localparam logic STATUS_DONE         = 1'b0;
   localparam logic STATUS_OUT_OF_RANGE = 1'b1;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  x_from;
      logic [7:0]  y_from;
      logic [8:0]  x_to;
      logic [8:0]  y_to;
      logic [7:0]  scroll_rows;
      logic [7:0]  color_index;
      logic [15:0] rgb565_in;
   } ffse_req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  pixel_index;
      logic [15:0] pixel_rgb565;
      logic        redraw_request;
   } ffse_rsp_type;

endpackage

// ===== sv/ffse_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ffse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/framebuffer_fill_scroll_engine_top.sv =====
// Palette write, poll, rejected or empty commands give their result strobe in the cycle after
// acceptance; a pixel read, a fill and a scroll strobe when their steps are done. One command at
// a time: busy stays high until the result. The fill and scroll loops move one pixel per cycle
// through the single frame store write port. Synchronous reset clears the sequencer and the redraw
// mark and sets the screen size registers to their reset values. The frame store and palette
// are not cleared; results cannot be stalled by the receiver.
module framebuffer_fill_scroll_engine_top
   import ffse_pkg::*;
#(
   parameter int FB_WIDTH  = 160,
   parameter int FB_HEIGHT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ffse_req_type req_word,
   output logic         rsp_valid,
   output ffse_rsp_type rsp_word,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [8:0]   csr_wdata
);

   localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT;
   localparam int AW = $clog2(STORE_SIZE);
   localparam int PW = $clog2(STORE_SIZE + 1);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_FILL_SET = 4'd1;
   localparam logic [3:0] ST_FILL     = 4'd2;
   localparam logic [3:0] ST_SC_DST   = 4'd3;
   localparam logic [3:0] ST_SC_SRC   = 4'd4;
   localparam logic [3:0] ST_SC_END   = 4'd5;
   localparam logic [3:0] ST_SCROLL   = 4'd6;
   localparam logic [3:0] ST_RD_ADDR  = 4'd7;
   localparam logic [3:0] ST_RD_PAL   = 4'd8;
   localparam logic [3:0] ST_RD_OUT   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [8:0]    screen_width_ff, screen_width_in;
   logic [8:0]    screen_height_ff, screen_height_in;
   logic          pending_ff, pending_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rd_pending_ff, rd_pending_in;
   ffse_rsp_type  rsp_ff, rsp_in;

   logic [7:0]    x_ff, x_in;
   logic [7:0]    y_ff, y_in;
   logic [7:0]    x_from_ff, x_from_in;
   logic [8:0]    x_to_ff, x_to_in;
   logic [8:0]    y_to_ff, y_to_in;
   logic [7:0]    color_ff, color_in;
   logic [8:0]    src_row_ff, src_row_in;
   logic [7:0]    pix_ff, pix_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] row_base_ff, row_base_in;
   logic [PW-1:0] src_ff, src_in;
   logic [PW-1:0] dst_ff, dst_in;
   logic [PW-1:0] end_ff, end_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;

   logic [8:0]    w_eff;
   logic [8:0]    h_eff;
   logic          accept;
   logic [9:0]    src_row_sum;
   logic          fill_nonempty;
   logic          fill_out;
   logic          scroll_out;
   logic          scroll_copy;
   logic          read_out;
   logic [8:0]    mul_row;
   logic [17:0]   mul_full;
   logic [PW-1:0] fill_addr;
   logic [PW-1:0] read_addr;

   logic          fb_we;
   logic [AW-1:0] fb_waddr;
   logic [7:0]    fb_wdata;
   logic [AW-1:0] fb_raddr;
   logic [7:0]    fb_rdata;
   logic          pal_we;
   logic [7:0]    pal_raddr;
   logic [15:0]   pal_rdata;

   function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [8:0] maxv);
      logic [8:0] r;
      r = v;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   assign w_eff = clamp_dim(screen_width_ff, 9'(FB_WIDTH));
   assign h_eff = clamp_dim(screen_height_ff, 9'(FB_HEIGHT));

   assign accept        = start && !busy;
   assign src_row_sum   = {2'b00, req_word.y_from} + {2'b00, req_word.scroll_rows};
   assign fill_nonempty = (req_word.x_to > {1'b0, req_word.x_from}) &&
                          (req_word.y_to > {1'b0, req_word.y_from});
   assign fill_out      = (req_word.x_to > w_eff) || (req_word.y_to > h_eff);
   assign scroll_out    = req_word.y_to > h_eff;
   assign scroll_copy   = src_row_sum < {1'b0, req_word.y_to};
   assign read_out      = ({1'b0, req_word.x_from} >= w_eff) ||
                          ({1'b0, req_word.y_from} >= h_eff);

   assign mul_full  = mul_row * w_eff;
   assign prod_in   = mul_full[PW-1:0];
   assign fill_addr = row_base_ff + PW'(x_ff);
   assign read_addr = prod_ff + PW'(x_from_ff);

   always_comb begin
      state_in         = state_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      pending_in       = pending_ff;
      rsp_valid_in     = 1'b0;
      rsp_in           = '0;
      rd_pending_in    = rd_pending_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      x_from_in        = x_from_ff;
      x_to_in          = x_to_ff;
      y_to_in          = y_to_ff;
      color_in         = color_ff;
      src_row_in       = src_row_ff;
      pix_in           = pix_ff;
      row_base_in      = row_base_ff;
      src_in           = src_ff;
      dst_in           = dst_ff;
      end_in           = end_ff;
      wr_addr_in       = wr_addr_ff;
      mul_row          = {1'b0, req_word.y_from};
      fb_we            = 1'b0;
      fb_waddr         = '0;
      fb_wdata         = '0;
      fb_raddr         = '0;
      pal_we           = 1'b0;
      pal_raddr        = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: begin
               screen_width_in = csr_wdata;
            end
            CSR_SCREEN_HEIGHT: begin
               screen_height_in = csr_wdata;
            end
            default: begin
               screen_width_in = screen_width_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in       = req_word.x_from;
               y_in       = req_word.y_from;
               x_from_in  = req_word.x_from;
               x_to_in    = req_word.x_to;
               y_to_in    = req_word.y_to;
               color_in   = req_word.color_index;
               src_row_in = src_row_sum[8:0];
               case (req_word.op)
                  OP_FILL: begin
                     if (!fill_nonempty) begin
                        rsp_valid_in = 1'b1;
                     end else if (fill_out) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_OUT_OF_RANGE;
                     end else begin
                        pending_in = 1'b1;
                        state_in   = ST_FILL_SET;
                     end
                  end
                  OP_SCROLL: begin
                     if (scroll_out) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_OUT_OF_RANGE;
                     end else begin
                        pending_in = 1'b1;
                        if (scroll_copy) begin
                           state_in = ST_SC_DST;
                        end else begin
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (read_out) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_OUT_OF_RANGE;
                     end else begin
                        state_in = ST_RD_ADDR;
                     end
                  end
                  OP_PAL_WRITE: begin
                     pal_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  OP_POLL: begin
                     rsp_in.redraw_request = pending_ff;
                     pending_in            = 1'b0;
                     rsp_valid_in          = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_FILL_SET: begin
            row_base_in = prod_ff;
            state_in    = ST_FILL;
         end
         ST_FILL: begin
            fb_we    = 1'b1;
            fb_waddr = fill_addr[AW-1:0];
            fb_wdata = color_ff;
            if ({1'b0, x_ff} == x_to_ff - 9'd1) begin
               x_in = x_from_ff;
               if ({1'b0, y_ff} == y_to_ff - 9'd1) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end else begin
                  y_in        = y_ff + 8'd1;
                  row_base_in = row_base_ff + PW'(w_eff);
               end
            end else begin
               x_in = x_ff + 8'd1;
            end
         end
         ST_SC_DST: begin
            dst_in   = prod_ff;
            mul_row  = src_row_ff;
            state_in = ST_SC_SRC;
         end
         ST_SC_SRC: begin
            src_in   = prod_ff;
            mul_row  = y_to_ff;
            state_in = ST_SC_END;
         end
         ST_SC_END: begin
            end_in        = prod_ff;
            rd_pending_in = 1'b0;
            state_in      = ST_SCROLL;
         end
         ST_SCROLL: begin
            if (rd_pending_ff) begin
               fb_we    = 1'b1;
               fb_waddr = wr_addr_ff;
               fb_wdata = fb_rdata;
            end
            if (src_ff != end_ff) begin
               fb_raddr      = src_ff[AW-1:0];
               src_in        = src_ff + PW'(1);
               dst_in        = dst_ff + PW'(1);
               wr_addr_in    = dst_ff[AW-1:0];
               rd_pending_in = 1'b1;
            end else begin
               rd_pending_in = 1'b0;
               if (!rd_pending_ff) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_RD_ADDR: begin
            fb_raddr = read_addr[AW-1:0];
            state_in = ST_RD_PAL;
         end
         ST_RD_PAL: begin
            pal_raddr = fb_rdata;
            pix_in    = fb_rdata;
            state_in  = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.pixel_index  = pix_ff;
            rsp_in.pixel_rgb565 = pal_rdata;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         pending_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rd_pending_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         pending_ff       <= pending_in;
         rsp_valid_ff     <= rsp_valid_in;
         rd_pending_ff    <= rd_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x_from_ff   <= x_from_in;
      x_to_ff     <= x_to_in;
      y_to_ff     <= y_to_in;
      color_ff    <= color_in;
      src_row_ff  <= src_row_in;
      pix_ff      <= pix_in;
      prod_ff     <= prod_in;
      row_base_ff <= row_base_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      end_ff      <= end_in;
      wr_addr_ff  <= wr_addr_in;
   end

   ffse_ram #(
      .WIDTH(8),
      .DEPTH(STORE_SIZE)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (fb_we),
      .wr_addr(fb_waddr),
      .wr_data(fb_wdata),
      .rd_addr(fb_raddr),
      .rd_data(fb_rdata)
   );

   ffse_ram #(
      .WIDTH(16),
      .DEPTH(256)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(req_word.color_index),
      .wr_data(req_word.rgb565_in),
      .rd_addr(pal_raddr),
      .rd_data(pal_rdata)
   );

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // A result word is only shown once the sequencer has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_fill_in_rect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (({1'b0, x_ff} < x_to_ff) && ({1'b0, y_ff} < y_to_ff)))
      else $error("fill cursor left the rectangle");

   // The copy never writes ahead of its read pointer, so ascending order is safe.
   a_scroll_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> ((src_ff <= end_ff) && (dst_ff <= src_ff)))
      else $error("scroll pointers out of order");

   a_poll_clears: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.op == OP_POLL) |=> !pending_ff)
      else $error("redraw mark not cleared by poll");
`endif

endmodule

// ===== tb/ffse_result_checker.sv =====
// Result checker for the frame buffer fill and scroll engine.
// Watches the command, result and register ports, predicts every result word and compares it.
// Depends on ffse_pkg for the word types, opcodes, register indexes and status codes.
module ffse_result_checker
   import ffse_pkg::*;
#(
   parameter int FB_WIDTH  = 160,
   parameter int FB_HEIGHT = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  ffse_req_type req,
   input  logic         rsp_valid,
   input  ffse_rsp_type rsp,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [8:0]   csr_wdata,
   output int           mismatches,
   output int           outstanding
);

   localparam int STORE_DEPTH = FB_WIDTH * FB_HEIGHT;

   logic [7:0]   frame_pixels [STORE_DEPTH];
   logic [15:0]  palette_colors [256];
   logic         redraw_mark;
   logic [8:0]   width_reg;
   logic [8:0]   height_reg;
   ffse_rsp_type expected_words [$];

   function automatic int clamp_size(logic [8:0] value, int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   function automatic ffse_rsp_type predict_command(ffse_req_type c);
      ffse_rsp_type r;
      int w, h, x, y, i, src_row, count, dst, src;
      r = '0;
      r.status = STATUS_DONE;
      w = clamp_size(width_reg, FB_WIDTH);
      h = clamp_size(height_reg, FB_HEIGHT);
      case (c.op)
         OP_FILL: begin
            if (c.x_to > c.x_from && c.y_to > c.y_from) begin
               if (c.x_to > w || c.y_to > h) begin
                  r.status = STATUS_OUT_OF_RANGE;
               end else begin
                  for (y = c.y_from; y < c.y_to; y++)
                     for (x = c.x_from; x < c.x_to; x++)
                        frame_pixels[(y * w + x) % STORE_DEPTH] = c.color_index;
                  redraw_mark = 1'b1;
               end
            end
         end
         OP_SCROLL: begin
            if (c.y_to > h) begin
               r.status = STATUS_OUT_OF_RANGE;
            end else begin
               src_row = c.y_from + c.scroll_rows;
               if (src_row < c.y_to) begin
                  count = (c.y_to - src_row) * w;
                  dst = c.y_from * w;
                  src = src_row * w;
                  for (i = 0; i < count; i++)
                     frame_pixels[(dst + i) % STORE_DEPTH] = frame_pixels[(src + i) % STORE_DEPTH];
               end
               redraw_mark = 1'b1;
            end
         end
         OP_READ: begin
            if (c.x_from >= w || c.y_from >= h) begin
               r.status = STATUS_OUT_OF_RANGE;
            end else begin
               r.pixel_index = frame_pixels[(c.y_from * w + c.x_from) % STORE_DEPTH];
               r.pixel_rgb565 = palette_colors[r.pixel_index];
            end
         end
         OP_PAL_WRITE: begin
            palette_colors[c.color_index] = c.rgb565_in;
         end
         OP_POLL: begin
            r.redraw_request = redraw_mark;
            redraw_mark = 1'b0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t result check: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_word(ffse_rsp_type got);
      ffse_rsp_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("result word with none outstanding", int'(got), 0);
      end else begin
         want = expected_words.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         if (got.pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", got.pixel_index, want.pixel_index);
         if (got.pixel_rgb565 !== want.pixel_rgb565)
            report_mismatch("pixel_rgb565", got.pixel_rgb565, want.pixel_rgb565);
         if (got.redraw_request !== want.redraw_request)
            report_mismatch("redraw_request", got.redraw_request, want.redraw_request);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         mismatches = 0;
         redraw_mark = 1'b0;
         width_reg = SCREEN_WIDTH_RESET;
         height_reg = SCREEN_HEIGHT_RESET;
      end else begin
         if (rsp_valid)
            check_word(rsp);
         if (start && !busy)
            expected_words.push_back(predict_command(req));
         if (csr_we) begin
            if (csr_index == CSR_SCREEN_WIDTH)
               width_reg = csr_wdata;
            else
               height_reg = csr_wdata;
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

// ===== tb/framebuffer_fill_scroll_engine_top_tb.sv =====
// Testbench top for the frame buffer fill and scroll engine: drives directed and random
// commands in bursts across several screen sizes and gives the verdict.
// Depends on ffse_pkg, framebuffer_fill_scroll_engine_top and ffse_result_checker.
module framebuffer_fill_scroll_engine_top_tb;
   import ffse_pkg::*;

   localparam int FB_WIDTH = 160;
   localparam int FB_HEIGHT = 128;
   localparam int CLOCK_PERIOD = 20;
   localparam int TIMEOUT_CYCLES = 10000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [2:0] OP_UNKNOWN_LOW = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HIGH = 3'd7;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   ffse_req_type req;
   logic         rsp_valid;
   ffse_rsp_type rsp;
   logic         csr_we;
   logic         csr_index;
   logic [8:0]   csr_wdata;
   int           mismatches;
   int           outstanding;

   int           cur_width = FB_WIDTH;
   int           cur_height = FB_HEIGHT;
   int           burst_left = 0;
   logic         palette_written [256];
   logic [7:0]   palette_list [$];

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   framebuffer_fill_scroll_engine_top #(
      .FB_WIDTH (FB_WIDTH),
      .FB_HEIGHT(FB_HEIGHT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ffse_result_checker #(
      .FB_WIDTH (FB_WIDTH),
      .FB_HEIGHT(FB_HEIGHT)
   ) result_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   function automatic ffse_req_type command(logic [2:0] op, int xf, int yf, int xt, int yt,
                                            int rows, int color, int rgb);
      ffse_req_type c;
      c.op = op;
      c.x_from = 8'(xf);
      c.y_from = 8'(yf);
      c.x_to = 9'(xt);
      c.y_to = 9'(yt);
      c.scroll_rows = 8'(rows);
      c.color_index = 8'(color);
      c.rgb565_in = 16'(rgb);
      return c;
   endfunction

   // Fills only use colors whose palette entry is set, so every pixel read has a defined color.
   function automatic logic [7:0] fill_color();
      return palette_list[$urandom_range(palette_list.size() - 1)];
   endfunction

   function automatic ffse_req_type random_command();
      ffse_req_type c;
      logic [95:0] noise;
      int pick, sel, span;
      noise = {$urandom, $urandom, $urandom};
      c = noise[$bits(ffse_req_type)-1:0];
      pick = $urandom_range(99);
      sel = $urandom_range(19);
      if (pick < 30) begin
         c.op = OP_FILL;
         c.color_index = fill_color();
         if (sel == 0) begin
            c.x_from = '0;
            c.y_from = '0;
            c.x_to = 9'(cur_width);
            c.y_to = 9'(cur_height);
         end else if (sel <= 3) begin
            c.x_to = 9'($urandom_range(256));
            c.y_to = 9'($urandom_range(256));
         end else begin
            c.x_from = 8'($urandom_range(cur_width - 1));
            span = cur_width - c.x_from;
            c.x_to = 9'(c.x_from + $urandom_range(span < 12 ? span : 12));
            c.y_from = 8'($urandom_range(cur_height - 1));
            span = cur_height - c.y_from;
            c.y_to = 9'(c.y_from + $urandom_range(span < 12 ? span : 12));
         end
      end else if (pick < 48) begin
         c.op = OP_SCROLL;
         if (sel == 0) begin
            c.y_from = '0;
            c.y_to = 9'(cur_height);
            c.scroll_rows = 8'($urandom_range(3));
         end else if (sel <= 3) begin
            c.y_to = 9'($urandom_range(256));
         end else begin
            c.y_to = 9'($urandom_range(cur_height, 1));
            span = c.y_to;
            c.y_from = 8'(c.y_to - $urandom_range(span < 6 ? span : 6));
            c.scroll_rows = 8'($urandom_range(3));
         end
      end else if (pick < 72) begin
         c.op = OP_READ;
         if (sel > 2) begin
            c.x_from = 8'($urandom_range(cur_width - 1));
            c.y_from = 8'($urandom_range(cur_height - 1));
         end
      end else if (pick < 84) begin
         c.op = OP_PAL_WRITE;
      end else if (pick < 96) begin
         c.op = OP_POLL;
      end else begin
         c.op = 3'($urandom_range(OP_UNKNOWN_HIGH, OP_UNKNOWN_LOW));
      end
      return c;
   endfunction

   // The sender works in bursts; between bursts start drops for a random gap, or not at all.
   task automatic send_command(ffse_req_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(9, 1);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      if (c.op == OP_PAL_WRITE && !palette_written[c.color_index]) begin
         palette_written[c.color_index] = 1'b1;
         palette_list.push_back(c.color_index);
      end
      start <= 1'b1;
      req <= c;
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [8:0] data);
      int value;
      settle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      value = (data == 0) ? 1 : int'(data);
      if (index == CSR_SCREEN_WIDTH)
         cur_width = (value > FB_WIDTH) ? FB_WIDTH : value;
      else
         cur_height = (value > FB_HEIGHT) ? FB_HEIGHT : value;
   endtask

   task automatic run_random(int count);
      repeat (count) send_command(random_command());
   endtask

   initial begin
      ffse_req_type c;
      foreach (palette_written[i]) palette_written[i] = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The first full-screen fill defines every pixel that any later size can address.
      send_command(command(OP_PAL_WRITE, 0, 0, 0, 0, 0, 8'h00, 16'h0000));
      send_command(command(OP_PAL_WRITE, 0, 0, 0, 0, 0, 8'hFF, 16'hFFFF));
      send_command(command(OP_FILL, 0, 0, FB_WIDTH, FB_HEIGHT, 0, 8'hFF, 0));
      send_command(command(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_READ, 0, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_READ, FB_WIDTH - 1, FB_HEIGHT - 1, 0, 0, 0, 0, 0));
      send_command(command(OP_READ, FB_WIDTH, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_READ, 255, 255, 0, 0, 0, 0, 0));
      send_command(command(OP_FILL, 10, 20, 10, 30, 0, 8'h00, 0));
      send_command(command(OP_FILL, 255, 255, 0, 256, 0, 8'h00, 0));
      send_command(command(OP_FILL, 0, 0, FB_WIDTH + 1, 1, 0, 8'h00, 0));
      send_command(command(OP_FILL, 0, 0, 256, 256, 0, 8'h00, 0));
      send_command(command(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_FILL, 1, 2, 5, 6, 0, 8'h00, 0));
      send_command(command(OP_PAL_WRITE, 0, 0, 0, 0, 0, 8'h55, 16'hAAAA));
      send_command(command(OP_FILL, FB_WIDTH - 10, FB_HEIGHT - 8, FB_WIDTH, FB_HEIGHT, 0,
                           8'h55, 0));
      send_command(command(OP_SCROLL, 0, 0, 0, FB_HEIGHT, 0, 0, 0));
      send_command(command(OP_SCROLL, 0, 0, 0, 10, 3, 0, 0));
      send_command(command(OP_SCROLL, 5, 0, 0, 10, 255, 0, 0));
      send_command(command(OP_SCROLL, 255, 0, 0, FB_HEIGHT, 0, 0, 0));
      send_command(command(OP_SCROLL, 0, 0, 0, 256, 1, 0, 0));
      send_command(command(OP_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_command(command(OP_READ, 2, 0, 0, 0, 0, 0, 0));
      for (int op = OP_UNKNOWN_LOW; op <= OP_UNKNOWN_HIGH; op++) begin
         c = random_command();
         c.op = 3'(op);
         send_command(c);
      end
      run_random(15);

      write_register(CSR_SCREEN_WIDTH, 9'd0);
      write_register(CSR_SCREEN_HEIGHT, 9'd511);
      run_random(10);

      write_register(CSR_SCREEN_WIDTH, 9'd256);
      write_register(CSR_SCREEN_HEIGHT, 9'd1);
      run_random(10);

      write_register(CSR_SCREEN_WIDTH, 9'd8);
      write_register(CSR_SCREEN_HEIGHT, 9'd8);
      run_random(15);

      write_register(CSR_SCREEN_WIDTH, 9'($urandom_range(FB_WIDTH, 1)));
      write_register(CSR_SCREEN_HEIGHT, 9'($urandom_range(FB_HEIGHT, 1)));
      run_random(13);

      write_register(CSR_SCREEN_WIDTH, 9'(FB_WIDTH));
      write_register(CSR_SCREEN_HEIGHT, 9'(FB_HEIGHT));
      run_random(10);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("tb: failure");
      $finish;
   end

endmodule
